// File: rtl/lwsd_pkg.sv
// ---------------------------------------------------------------------------
// lwsd_pkg: shared constants for the least-wait server dispatcher
// Field widths, reset values of the configuration registers and their
// register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package lwsd_pkg;

  // default pool size
  localparam int MAX_SERVERS_DEF = 16;

  // transaction field widths
  localparam int ELAPSED_W  = 16;
  localparam int SERVICE_W  = 8;
  localparam int WAIT_W     = 16;
  localparam int SRV_IDX_W  = 4;
  localparam int COUNT_W    = 16;

  // configuration port
  localparam int ACTIVE_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SERVERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_LIMIT  = 2'd1;

  localparam logic [ACTIVE_W-1:0]  ACTIVE_RST = 5'd16;
  localparam logic [SERVICE_W-1:0] LIMIT_RST  = 8'd60;

  // saturation limits
  localparam logic [WAIT_W-1:0]  WORK_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

// File: rtl/lwsd_ram.sv
// ---------------------------------------------------------------------------
// lwsd_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered and returns
// the old contents on a same-address write.
// ---------------------------------------------------------------------------
`default_nettype none

module lwsd_ram #(
  parameter int WIDTH = lwsd_pkg::WAIT_W,
  parameter int DEPTH = lwsd_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/least_wait_server_dispatch_core.sv
// ---------------------------------------------------------------------------
// least_wait_server_dispatch_core: least-wait job dispatcher
// Ages the remaining work of every active server, picks the first idle
// server or the one with least work, and books the job there.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one job per transaction:
//   elapsed time since the previous job and its requested service time.
//   Result channel (out_valid / out_stall) returns the job's wait, the
//   chosen server and that server's served count, one per job.
//   cfg_we writes register cfg_index (0: active servers, 1: service limit);
//   other indexes are ignored. The user must write only while the block is
//   idle; the block itself does not enforce this.
//   Jobs are taken one at a time: in_stall holds until the sequencer is
//   idle again. The scan walks the work memory one entry a cycle through a
//   single subtract/compare unit, with its read-ahead and drain; accept
//   precedes it, and work write-back and count update follow it.
//   A finished result waits in the output register; the next job may be
//   accepted meanwhile, but its own result holds until the register frees.
//   Reset stalls the input, clears all server state at once through
//   per-entry valid bits and restores 16 active servers and a limit of 60.
// ---------------------------------------------------------------------------
`default_nettype none

module least_wait_server_dispatch_core #(
  parameter int MAX_SERVERS = lwsd_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [lwsd_pkg::ELAPSED_W-1:0]     in_elapsed,
  input  wire logic [lwsd_pkg::SERVICE_W-1:0]     in_service_time,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [lwsd_pkg::WAIT_W-1:0]        out_wait_time,
  output logic      [lwsd_pkg::SRV_IDX_W-1:0]     out_server_index,
  output logic      [lwsd_pkg::COUNT_W-1:0]       out_served_count,
  // configuration port
  input  wire logic                               cfg_we,
  input  wire logic [lwsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lwsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import lwsd_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_WORK   = 2'd2;
  localparam logic [1:0] ST_COUNT  = 2'd3;

  // control registers
  logic [1:0]             state_r;
  logic [CNT_W-1:0]       rd_idx_r;
  logic                   pend_r;
  logic                   found_r;
  logic                   out_valid_r;
  logic [ACTIVE_W-1:0]    active_r;
  logic [SERVICE_W-1:0]   limit_r;
  logic [MAX_SERVERS-1:0] rw_vld_r;
  logic [MAX_SERVERS-1:0] js_vld_r;

  // datapath registers
  logic [IDX_W-1:0]       cmp_idx_r;
  logic [IDX_W-1:0]       pick_r;
  logic [WAIT_W:0]        best_r;
  logic [ELAPSED_W-1:0]   el_r;
  logic [SERVICE_W-1:0]   svc_r;
  logic                   rw_rvld_r;
  logic                   js_rvld_r;
  logic [WAIT_W-1:0]      wait_r;
  logic [SRV_IDX_W-1:0]   srv_idx_r;
  logic [COUNT_W-1:0]     count_r;

  // combinational
  logic [CNT_W-1:0]       n_eff;
  logic                   accept;
  logic                   out_free;
  logic                   out_load;
  logic                   scan_done;
  logic [WAIT_W-1:0]      rw_rdata;
  logic [WAIT_W-1:0]      rw_eff;
  logic [WAIT_W:0]        diff;
  logic [WAIT_W-1:0]      aged;
  logic [WAIT_W:0]        sum;
  logic [WAIT_W-1:0]      sum_sat;
  logic [COUNT_W-1:0]     js_rdata;
  logic [COUNT_W-1:0]     js_eff;
  logic [COUNT_W-1:0]     js_inc;
  logic                   rw_we;
  logic [IDX_W-1:0]       rw_waddr;
  logic [WAIT_W-1:0]      rw_wdata;
  logic [IDX_W-1:0]       rd_addr;
  logic [SERVICE_W-1:0]   svc_clamped;
  logic [31:0]            pick_ext;

  // effective server count: zero acts as one, clamp to pool size
  always_comb begin
    if (active_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(active_r) > MAX_SERVERS) begin
      n_eff = CNT_W'(MAX_SERVERS);
    end else begin
      n_eff = CNT_W'(active_r);
    end
  end

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_COUNT) && out_free;
  assign scan_done = (rd_idx_r == n_eff) && !pend_r;
  assign rd_addr   = rd_idx_r[IDX_W-1:0];

  // clamp service time against the limit
  assign svc_clamped = (in_service_time > limit_r) ? limit_r : in_service_time;

  // shared unit: age one entry, floored at zero
  assign rw_eff = rw_rvld_r ? rw_rdata : '0;
  assign diff   = {1'b0, rw_eff} - {1'b0, el_r};
  assign aged   = diff[WAIT_W] ? '0 : diff[WAIT_W-1:0];

  // book the job on the chosen server, saturating
  assign sum     = {1'b0, best_r[WAIT_W-1:0]} + (WAIT_W + 1)'(svc_r);
  assign sum_sat = sum[WAIT_W] ? WORK_MAX : sum[WAIT_W-1:0];

  // served count, saturating
  assign js_eff = js_rvld_r ? js_rdata : '0;
  assign js_inc = (js_eff == COUNT_MAX) ? js_eff : js_eff + COUNT_W'(1);

  // work memory write: aged entries during scan, booked entry after
  assign rw_we    = ((state_r == ST_SCAN) && pend_r) || (state_r == ST_WORK);
  assign rw_waddr = (state_r == ST_WORK) ? pick_r : cmp_idx_r;
  assign rw_wdata = (state_r == ST_WORK) ? sum_sat : aged;

  assign pick_ext = 32'(pick_r);

  lwsd_ram #(
    .WIDTH (WAIT_W),
    .DEPTH (MAX_SERVERS)
  ) u_work_ram (
    .clk   (clk),
    .we    (rw_we),
    .waddr (rw_waddr),
    .wdata (rw_wdata),
    .raddr (rd_addr),
    .rdata (rw_rdata)
  );

  lwsd_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_SERVERS)
  ) u_count_ram (
    .clk   (clk),
    .we    (out_load),
    .waddr (pick_r),
    .wdata (js_inc),
    .raddr (pick_r),
    .rdata (js_rdata)
  );

  // control: sequencer, config, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= ACTIVE_RST;
      limit_r     <= LIMIT_RST;
      rw_vld_r    <= '0;
      js_vld_r    <= '0;
    end else begin
      // register writes; unknown indexes drop
      if (cfg_we) begin
        if (cfg_index == REG_ACTIVE_SERVERS) begin
          active_r <= cfg_wdata[ACTIVE_W-1:0];
        end else if (cfg_index == REG_SERVICE_LIMIT) begin
          limit_r <= cfg_wdata[SERVICE_W-1:0];
        end
      end

      // mark entries written
      if (rw_we) begin
        rw_vld_r[rw_waddr] <= 1'b1;
      end
      if (out_load) begin
        js_vld_r[pick_r] <= 1'b1;
      end

      // load or drain the result register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            rd_idx_r <= '0;
            pend_r   <= 1'b0;
            found_r  <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue the next read while the previous entry is compared
          if (rd_idx_r != n_eff) begin
            rd_idx_r <= rd_idx_r + CNT_W'(1);
            pend_r   <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r && !found_r && aged == '0) begin
            found_r <= 1'b1;
          end
          if (scan_done) begin
            state_r <= ST_WORK;
          end
        end
        ST_WORK: begin
          state_r <= ST_COUNT;
        end
        ST_COUNT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // datapath: job operands, search result, read tags, result payload
  always_ff @(posedge clk) begin
    rw_rvld_r <= rw_vld_r[rd_addr];
    js_rvld_r <= js_vld_r[pick_r];

    if (accept) begin
      el_r   <= in_elapsed;
      svc_r  <= svc_clamped;
      best_r <= '1;
      pick_r <= '0;
    end

    if (state_r == ST_SCAN) begin
      if (rd_idx_r != n_eff) begin
        cmp_idx_r <= rd_addr;
      end
      // first idle entry wins; otherwise track the strict minimum
      if (pend_r && !found_r) begin
        if (aged == '0) begin
          best_r <= '0;
          pick_r <= cmp_idx_r;
        end else if ({1'b0, aged} < best_r) begin
          best_r <= {1'b0, aged};
          pick_r <= cmp_idx_r;
        end
      end
    end

    if (out_load) begin
      wait_r    <= best_r[WAIT_W-1:0];
      srv_idx_r <= pick_ext[SRV_IDX_W-1:0];
      count_r   <= js_inc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_wait_time    = wait_r;
  assign out_server_index = srv_idx_r;
  assign out_served_count = count_r;

`ifndef NO_ASSERTIONS
  // an idle server found means the recorded wait is zero
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (best_r == '0))
    else $error("idle server found but recorded wait is nonzero");

  // the chosen server lies inside the active pool
  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WORK) |-> (pick_ext < 32'(n_eff)))
    else $error("chosen server outside the active pool");

  // an accepted job always starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SCAN))
    else $error("accepted job did not start a scan");

  // every booked job counts at least once
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && out_served_count != '0))
    else $error("result loaded with zero served count");
`endif

endmodule

`default_nettype wire

// File: verif/least_wait_server_dispatch_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// least_wait_server_dispatch_core_tb: self-checking bench for the dispatcher
// Sends jobs in random bursts while the result side stalls on its own
// pattern. Every accepted job is booked against a shadow of the server pool,
// and each result is compared field by field in order. The run steps
// through several pool sizes and service limits, stalls the result side
// for a long stretch, and drives one server's work into saturation.
// ---------------------------------------------------------------------------

module least_wait_server_dispatch_core_tb;
  import lwsd_pkg::*;

  localparam int POOL          = MAX_SERVERS_DEF;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_JOBS    = 140;
  localparam int SAT_JOBS      = 360;
  localparam int TIMEOUT_NS    = 40_000_000;
  localparam int MAX_PRINTS    = 30;

  // indexes beyond the register list, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [WAIT_W-1:0]    wait_time;
    logic [SRV_IDX_W-1:0] server_index;
    logic [COUNT_W-1:0]   served_count;
  } dispatch_result_t;

  // Shadow of the server pool plus the queue of answers still owed
  class dispatch_tracker;
    logic [WAIT_W-1:0]     work [POOL];
    logic [COUNT_W-1:0]    served [POOL];
    logic [ACTIVE_W-1:0]   active_cfg;
    logic [SERVICE_W-1:0]  limit_cfg;
    dispatch_result_t      owed_dispatches [$];
    int                    errors;

    function new();
      for (int i = 0; i < POOL; i++) begin
        work[i]   = '0;
        served[i] = '0;
      end
      active_cfg = ACTIVE_RST;
      limit_cfg  = LIMIT_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ACTIVE_SERVERS: active_cfg = data[ACTIVE_W-1:0];
        REG_SERVICE_LIMIT:  limit_cfg  = data[SERVICE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_dispatches.size();
    endfunction

    // Age the pool, pick the server and book the job
    function void book_job(logic [ELAPSED_W-1:0] elapsed, logic [SERVICE_W-1:0] service);
      int               n;
      int               pick;
      bit               found;
      logic [WAIT_W:0]  best;
      logic [WAIT_W:0]  sum;
      logic [SERVICE_W-1:0] charge;
      dispatch_result_t res;
      n = (active_cfg == 0) ? 1 : ((active_cfg > POOL) ? POOL : int'(active_cfg));
      for (int i = 0; i < n; i++)
        work[i] = (work[i] > elapsed) ? work[i] - elapsed : '0;
      pick  = 0;
      found = 1'b0;
      best  = '1;
      for (int i = 0; i < n; i++) begin
        if (!found) begin
          if (work[i] == 0) begin
            pick  = i;
            found = 1'b1;
          end else if ({1'b0, work[i]} < best) begin
            best = {1'b0, work[i]};
            pick = i;
          end
        end
      end
      charge = (service > limit_cfg) ? limit_cfg : service;
      res.wait_time = work[pick];
      if (served[pick] != COUNT_MAX)
        served[pick] = served[pick] + 1'b1;
      sum = {1'b0, work[pick]} + charge;
      work[pick] = (sum > {1'b0, WORK_MAX}) ? WORK_MAX : sum[WAIT_W-1:0];
      res.server_index = pick[SRV_IDX_W-1:0];
      res.served_count = served[pick];
      owed_dispatches.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("mismatch at %0t: %s got %0d wanted %0d", $time, what, got, want);
    endtask

    task check_dispatch(logic [WAIT_W-1:0] w, logic [SRV_IDX_W-1:0] idx,
                        logic [COUNT_W-1:0] cnt);
      dispatch_result_t want;
      if (owed_dispatches.size() == 0) begin
        report("result with no job booked", 0, 0);
        return;
      end
      want = owed_dispatches.pop_front();
      if (w !== want.wait_time)
        report("wait_time", 32'(w), 32'(want.wait_time));
      if (idx !== want.server_index)
        report("server_index", 32'(idx), 32'(want.server_index));
      if (cnt !== want.served_count)
        report("served_count", 32'(cnt), 32'(want.served_count));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [ELAPSED_W-1:0]  in_elapsed;
  logic [SERVICE_W-1:0]  in_service_time;
  logic                  out_valid;
  logic                  out_stall;
  logic [WAIT_W-1:0]     out_wait_time;
  logic [SRV_IDX_W-1:0]  out_server_index;
  logic [COUNT_W-1:0]    out_served_count;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dispatch_tracker tracker = new();
  bit steady = 1'b0;
  int pressure_req = 0;
  int pressure_seen = 0;

  // pool size and service limit per phase, extremes and masking included
  logic [7:0] phase_active [10] = '{8'd1, 8'hE0, 8'd31, 8'd17, 8'd16,
                                   8'd2, 8'd5, 8'h29, 8'd1, 8'd12};
  logic [7:0] phase_limit  [10] = '{8'd0, 8'd255, 8'd255, 8'd100, 8'd255,
                                   8'd1, 8'd128, 8'd200, 8'd255, 8'd30};

  least_wait_server_dispatch_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_elapsed       (in_elapsed),
    .in_service_time  (in_service_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wait_time    (out_wait_time),
    .out_server_index (out_server_index),
    .out_served_count (out_served_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check every result transaction against the oldest booked job
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_dispatch(out_wait_time, out_server_index, out_served_count);
  end

  // Stall the result side in patterns; hold off for a long stretch on request
  initial begin : receiver
    int mode;
    int span;
    int tick;
    out_stall <= 1'b0;
    tick = 0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 128);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (pressure_req != pressure_seen) begin
          pressure_seen = pressure_req;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        if (steady)
          out_stall <= 1'b0;
        else
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ((tick % 8) < 5);
          endcase
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("least_wait_server_dispatch_core_tb failed");
    $finish;
  end

  // Offer one job and wait for the transaction; book it on acceptance
  task automatic send_job(input logic [ELAPSED_W-1:0] e, input logic [SERVICE_W-1:0] s);
    in_valid        <= 1'b1;
    in_elapsed      <= e;
    in_service_time <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.book_job(e, s);
  endtask

  // Drop valid and wait until every booked job has answered
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [7:0] active_data, input logic [7:0] limit_data);
    drain();
    write_reg(REG_ACTIVE_SERVERS, active_data);
    write_reg(REG_SERVICE_LIMIT, limit_data);
    write_reg(REG_SPARE_2, 8'($urandom_range(0, 255)));
    write_reg(REG_SPARE_3, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Favor short gaps so work builds up, with some large ones that clear it
  function automatic void pick_job(output logic [ELAPSED_W-1:0] e,
                                   output logic [SERVICE_W-1:0] s);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)       e = '0;
    else if (r < 6)  e = 16'($urandom_range(0, 63));
    else if (r < 8)  e = 16'($urandom_range(0, 1023));
    else if (r == 8) e = 16'($urandom_range(0, 65535));
    else             e = 16'hFFFF - 16'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    if (r < 2)       s = 8'hFF;
    else if (r == 2) s = '0;
    else             s = 8'($urandom_range(0, 255));
  endfunction

  // Send jobs in bursts separated by random gaps
  task automatic run_jobs(input int count);
    int left;
    int gap;
    logic [ELAPSED_W-1:0] e;
    logic [SERVICE_W-1:0] s;
    left = 0;
    for (int k = 0; k < count; k++) begin
      if (left == 0) begin
        left = $urandom_range(1, 24);
        gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pick_job(e, s);
      send_job(e, s);
      left--;
    end
  endtask

  initial begin : stimulus
    logic [ELAPSED_W-1:0] e;
    logic [SERVICE_W-1:0] s;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_elapsed      <= '0;
    in_service_time <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_ACTIVE_SERVERS;
    cfg_wdata       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: clamping edges, fill the pool, least-work pick, field extremes
    send_job(16'd0, 8'd0);
    send_job(16'd0, 8'hFF);
    send_job(16'd0, 8'd61);
    send_job(16'd0, 8'd60);
    for (int i = 0; i < 14; i++)
      send_job(16'd0, 8'(20 + 3 * i));
    send_job(16'd3, 8'd1);
    send_job(16'hFFFF, 8'hFF);
    send_job(16'h5555, 8'hAA);
    send_job(16'hAAAA, 8'h55);
    send_job(16'hFFFF, 8'h80);

    // Random phases over pool sizes and limits; stall the output hard twice
    for (int p = 0; p < 10; p++) begin
      apply_setting(phase_active[p], phase_limit[p]);
      if (p == 4 || p == 8)
        pressure_req++;
      run_jobs(PHASE_JOBS);
    end
    for (int p = 0; p < 2; p++) begin
      apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_jobs(PHASE_JOBS);
    end

    // Saturate one server's work, then let it age in small steps
    steady = 1'b1;
    apply_setting(8'd1, 8'd255);
    for (int k = 0; k < SAT_JOBS; k++) begin
      if (k < 300) begin
        e = '0;
        s = 8'hFF;
      end else begin
        e = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) : 16'd0;
        s = 8'($urandom_range(0, 255));
      end
      send_job(e, s);
    end
    steady = 1'b0;

    // Full pool again with server zero still loaded
    apply_setting(8'd16, 8'd60);
    run_jobs(60);

    drain();
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("least_wait_server_dispatch_core_tb passed");
    else
      $display("least_wait_server_dispatch_core_tb failed");
    $finish;
  end

endmodule
